### rtl/core/crq_pkg.sv
`default_nettype none

package crq_pkg;

	// Request codes
	localparam logic [2:0] REQ_ENQ    = 3'd0;
	localparam logic [2:0] REQ_DEQ    = 3'd1;
	localparam logic [2:0] REQ_SEARCH = 3'd2;
	localparam logic [2:0] REQ_HEAVY  = 3'd3;
	localparam logic [2:0] REQ_FEW    = 3'd4;
	localparam logic [2:0] REQ_SUM    = 3'd5;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam int ENTRY_W = 5;
	localparam int SUM_W   = 28;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [23:0] weight_in;
		logic [15:0] boxes_in;
		logic [55:0] plate_in;
		logic [63:0] driver_in;
	} crq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [55:0]        plate_out;
		logic [63:0]        driver_out;
		logic [23:0]        weight_out;
		logic [15:0]        boxes_out;
		logic [SUM_W-1:0]   total_weight;
		logic [ENTRY_W-1:0] entry_count;
		logic               is_full;
	} crq_rsp_t;

	typedef struct packed {
		logic [23:0] weight;
		logic [15:0] boxes;
		logic [55:0] plate;
		logic [63:0] driver;
	} crq_rec_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic enq_wr;
		logic deq_rd;
		logic deq_take;
		logic scan_start;
		logic scan_step;
	} crq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_enq;
		logic is_deq;
		logic is_query;
		logic full;
		logic empty;
		logic last;
	} crq_sts_t;

endpackage

`default_nettype wire

### rtl/core/circular_record_queue_with_queries.sv
// Steps: each request is decoded; an enqueue writes then, a dequeue reads and takes the head,
// a query (search, heaviest, fewest boxes, total) scans head to tail; empty or unused skip to done.
// Flow: one request at a time; a new beat is taken in the done cycle.
// Queries walk the single RAM read port
// one record per cycle. Results cannot be stalled: done is a one-cycle strobe.
// Reset (arst_n low) empties the queue; record storage is not cleared.
`default_nettype none

module circular_record_queue_with_queries import crq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	// Request channel: a beat is taken when start is high and busy is low
	input  wire logic     start,
	output logic          busy,
	input  wire crq_req_t req,
	// Result channel: valid for the single cycle in which done is high
	output logic          done,
	output crq_rsp_t      rsp
);

	crq_cmd_t cmd;
	crq_sts_t sts;

	// Sequence each request: decode, which starts one write, one read, or a scan
	// from head to tail that evaluates one record per cycle.
	crq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.sts   (sts)
	);

	// Hold the ring pointers, the record RAM and the query accumulators;
	// the result fields come straight from its registers.
	crq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

### rtl/core/crq_ram.sv
`default_nettype none

module crq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/crq_dp.sv
`default_nettype none

module crq_dp import crq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire crq_cmd_t cmd,
	output crq_sts_t      sts,
	input  wire crq_req_t req,
	output crq_rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	crq_req_t          req_q;
	logic [AW-1:0]     head_q, tail_q, scan_ptr_q;
	logic [CW-1:0]     count_q, left_q;
	logic              have_q;
	logic [23:0]       best_q;
	logic [SUM_W-1:0]  sum_q;
	logic [1:0]        stat_q;
	crq_rec_t          sel_q;

	crq_rec_t          wr_rec, rd_rec;
	logic [$bits(crq_rec_t)-1:0] rd_raw;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              take;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_rec = '{weight: req_q.weight_in, boxes: req_q.boxes_in,
		plate: req_q.plate_in, driver: req_q.driver_in};
	assign rd_rec  = crq_rec_t'(rd_raw);
	assign rd_en   = cmd.deq_rd | cmd.scan_start | cmd.scan_step;
	assign rd_addr = (cmd.deq_rd | cmd.scan_start) ? head_q : scan_ptr_q;

	crq_ram #(
		.WIDTH($bits(crq_rec_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.enq_wr),
		.waddr(tail_q),
		.wdata(wr_rec),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	always_comb begin
		sts.is_enq   = (req_q.req_type == REQ_ENQ);
		sts.is_deq   = (req_q.req_type == REQ_DEQ);
		sts.is_query = req_q.req_type inside {[REQ_SEARCH:REQ_SUM]};
		sts.full     = (count_q == CW'(DEPTH));
		sts.empty    = (count_q == '0);
		sts.last     = (left_q == CW'(1));
	end

	// Record picked up by the current scan beat
	always_comb begin
		case (req_q.req_type)
			REQ_SEARCH: take = !have_q && (rd_rec.plate == req_q.plate_in);
			REQ_HEAVY:  take = (rd_rec.weight > best_q);
			REQ_FEW:    take = !have_q || (24'(rd_rec.boxes) < best_q);
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.decode) begin
			if (sts.is_enq && sts.full) begin
				stat_q <= STAT_FULL;
			end else if (sts.is_deq && sts.empty) begin
				stat_q <= STAT_EMPTY;
			end else begin
				stat_q <= STAT_OK;
			end
			best_q <= '0;
			sum_q  <= '0;
		end
		if (cmd.deq_take) begin
			sel_q <= rd_rec;
		end
		if (cmd.scan_step) begin
			if (take) begin
				sel_q <= rd_rec;
				if (req_q.req_type == REQ_FEW) begin
					best_q <= 24'(rd_rec.boxes);
				end else begin
					best_q <= rd_rec.weight;
				end
			end
			sum_q <= sum_q + SUM_W'(rd_rec.weight);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			scan_ptr_q <= '0;
			left_q     <= '0;
			have_q     <= 1'b0;
		end else begin
			if (cmd.decode) begin
				have_q <= 1'b0;
			end
			if (cmd.enq_wr) begin
				tail_q  <= wrap_inc(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.deq_take) begin
				head_q  <= wrap_inc(head_q);
				count_q <= count_q - 1'b1;
				have_q  <= 1'b1;
			end
			if (cmd.scan_start) begin
				scan_ptr_q <= wrap_inc(head_q);
				left_q     <= count_q;
			end
			if (cmd.scan_step) begin
				scan_ptr_q <= wrap_inc(scan_ptr_q);
				left_q     <= left_q - 1'b1;
				if (take) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp.status       = stat_q;
		rsp.found        = have_q;
		rsp.plate_out    = have_q ? sel_q.plate  : '0;
		rsp.driver_out   = have_q ? sel_q.driver : '0;
		rsp.weight_out   = have_q ? sel_q.weight : '0;
		rsp.boxes_out    = have_q ? sel_q.boxes  : '0;
		rsp.total_weight = (req_q.req_type == REQ_SUM) ? sum_q : '0;
		rsp.entry_count  = ENTRY_W'(count_q);
		rsp.is_full      = sts.full;
	end

	logic [AW:0] head_plus_count;
	logic [AW:0] exp_tail;

	always_comb begin
		head_plus_count = {1'b0, head_q} + (AW+1)'(count_q);
		exp_tail = (head_plus_count >= (AW+1)'(DEPTH)) ?
			head_plus_count - (AW+1)'(DEPTH) : head_plus_count;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count above capacity");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == AW'(exp_tail))
		else $error("tail does not match head plus count");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_wr |-> !sts.full)
		else $error("write into a full queue");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> left_q != '0)
		else $error("scan beat with no records left");

endmodule

`default_nettype wire

### rtl/core/crq_ctrl.sv
`default_nettype none

module crq_ctrl import crq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	output crq_cmd_t      cmd,
	input  wire crq_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DEQ    = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0] state_q, state_d;

	assign busy = !((state_q == ST_IDLE) || (state_q == ST_DONE));
	assign done = (state_q == ST_DONE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE, ST_DONE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end else begin
					state_d  = ST_IDLE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = ST_DONE;
				if (sts.is_enq && !sts.full) begin
					cmd.enq_wr = 1'b1;
				end else if (sts.is_deq && !sts.empty) begin
					cmd.deq_rd = 1'b1;
					state_d    = ST_DEQ;
				end else if (sts.is_query && !sts.empty) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_DEQ: begin
				cmd.deq_take = 1'b1;
				state_d      = ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.last) begin
					state_d = ST_DONE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request not processed");

endmodule

`default_nettype wire
